[rtl/pff_pkg.sv]
// ----------------------------------------------------------------------------
// pff_pkg
// Shared types, constants and helpers of the printf field formatter.
// ----------------------------------------------------------------------------
package pff_pkg;

    localparam int MAX_WIDTH  = 32;
    localparam int RUN_LIMIT  = 32;
    localparam int W_CAP      = (MAX_WIDTH < RUN_LIMIT) ? MAX_WIDTH : RUN_LIMIT;
    localparam int VAL_W      = 32;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int NDIG       = 11;
    localparam int DIG_W      = 4 * NDIG;

    localparam logic [2:0] ACT_LITERAL = 3'd0;
    localparam logic [2:0] ACT_CHAR    = 3'd1;
    localparam logic [2:0] ACT_DEC     = 3'd2;
    localparam logic [2:0] ACT_OCT     = 3'd3;
    localparam logic [2:0] ACT_HEX     = 3'd4;

    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_UPPER = 8'h41;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] value;
        logic [5:0]  field_width;
        logic        zero_pad;
    } t_in;

    typedef struct packed {
        logic [7:0] char_out;
        logic       last;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_STRIP,
        ST_PREP,
        ST_PAD,
        ST_BODY
    } t_state;

    function automatic logic [7:0] digit_glyph(input logic [3:0] d);
        logic [7:0] g;
        if (d < 4'd10) begin
            g = CH_ZERO + {4'b0, d};
        end else begin
            g = CH_UPPER + {4'b0, d - 4'd10};
        end
        return g;
    endfunction

    function automatic logic [DIG_W-1:0] oct_digits(input logic [VAL_W-1:0] v);
        logic [3*NDIG-1:0] vx;
        logic [DIG_W-1:0]  d;
        vx = {{(3*NDIG-VAL_W){1'b0}}, v};
        for (int i = 0; i < NDIG; i++) begin
            d[4*i +: 4] = {1'b0, vx[3*i +: 3]};
        end
        return d;
    endfunction

endpackage

[rtl/pff_bcd.sv]
// ----------------------------------------------------------------------------
// pff_bcd
// Bit-serial binary to BCD converter, one value bit shifted in per cycle.
// ----------------------------------------------------------------------------
module pff_bcd import pff_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [VAL_W-1:0]  i_value,
    output logic [BCD_W-1:0]  o_bcd,
    output logic              o_done
);

    logic [VAL_W-1:0]         r_bin;
    logic [BCD_W-1:0]         r_bcd;
    logic [$clog2(VAL_W)-1:0] r_cnt;
    logic                     r_run;
    logic                     r_done;
    logic [BCD_W-1:0]         adj;

    always_comb begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
            adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ? r_bcd[4*i +: 4] + 4'd3
                                                       : r_bcd[4*i +: 4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == $clog2(VAL_W)'(VAL_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bin <= i_value;
            r_bcd <= '0;
        end else if (r_run) begin
            r_bin <= {r_bin[VAL_W-2:0], 1'b0};
            r_bcd <= {adj[BCD_W-2:0], r_bin[VAL_W-1]};
        end
    end

    assign o_bcd  = r_bcd;
    assign o_done = r_done;

endmodule

[rtl/printf_field_formatter_top.sv]
// ----------------------------------------------------------------------------
// printf_field_formatter_top
// Formats one pre-parsed printf directive into a run of ASCII characters.
// ----------------------------------------------------------------------------
// Usage:
//   Drive i_item and raise start; the directive is taken at a clock edge where
//   start is high and busy is low. busy stays high until the run is done.
//   Each character appears on o_result for one cycle with o_strobe high;
//   o_result.last marks the final character. The receiver cannot stall, so
//   every strobed beat is consumed in the cycle it appears.
// Timing:
//   Literal and unknown directives: a setup state, then the single beat.
//   Character directives: a setup state, then one beat per output character.
//   Hex and octal: leading zeros are stripped in the strip state, then a setup
//   state, then one beat per pad or digit character. Decimal first runs the
//   serial binary to BCD converter, one value bit per cycle. The longest run
//   from accept to the last beat is a one-digit decimal in a 32-wide field; the
//   next directive is taken at the earliest in the cycle after the last beat.
//   A zero character with no width produces no beats.
// Reset:
//   Synchronous, active low; the block returns to idle and drops any run.
// ----------------------------------------------------------------------------
module printf_field_formatter_top import pff_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_in  i_item,
    output logic busy,
    output logic o_strobe,
    output t_out o_result
);

    t_state             r_state, n_state;
    logic               r_num;
    logic [7:0]         r_chr;
    logic [7:0]         r_pad;
    logic [5:0]         r_width;
    logic [3:0]         r_blen;
    logic [5:0]         r_padn;
    logic [DIG_W-1:0]   r_dig;

    logic               bcd_start;
    logic [BCD_W-1:0]   bcd_val;
    logic               bcd_done;
    logic [5:0]         width_sat;
    logic [7:0]         body_chr;

    pff_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (bcd_start),
        .i_value (i_item.value),
        .o_bcd   (bcd_val),
        .o_done  (bcd_done)
    );

    assign width_sat = (i_item.field_width > 6'(W_CAP)) ? 6'(W_CAP) : i_item.field_width;
    assign body_chr  = r_num ? digit_glyph(r_dig[DIG_W-1 -: 4]) : r_chr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        busy      = 1'b1;
        bcd_start = 1'b0;
        o_strobe  = 1'b0;
        o_result  = '{char_out: body_chr, last: 1'b0};
        case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    case (i_item.action)
                        ACT_DEC: begin
                            bcd_start = 1'b1;
                            n_state   = ST_CONV;
                        end
                        ACT_OCT, ACT_HEX: n_state = ST_STRIP;
                        default:          n_state = ST_PREP;
                    endcase
                end
            end
            ST_CONV: begin
                if (bcd_done) begin
                    n_state = ST_STRIP;
                end
            end
            ST_STRIP: begin
                if (r_dig[DIG_W-1 -: 4] == 4'd0 && r_blen > 4'd1) begin
                    n_state = ST_STRIP;
                end else begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                if (r_width > {2'b0, r_blen}) begin
                    n_state = ST_PAD;
                end else if (r_blen != 4'd0) begin
                    n_state = ST_BODY;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_PAD: begin
                o_strobe = 1'b1;
                o_result = '{char_out: r_pad, last: (r_padn == 6'd1 && r_blen == 4'd0)};
                if (r_padn == 6'd1) begin
                    n_state = (r_blen != 4'd0) ? ST_BODY : ST_IDLE;
                end
            end
            ST_BODY: begin
                o_strobe = 1'b1;
                o_result = '{char_out: body_chr, last: (r_blen == 4'd1)};
                if (r_blen == 4'd1) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_pad   <= i_item.zero_pad ? CH_ZERO : CH_SPACE;
                r_width <= width_sat;
                r_chr   <= i_item.value[7:0];
                r_num   <= 1'b1;
                r_blen  <= 4'(NDIG);
                case (i_item.action)
                    ACT_LITERAL: begin
                        r_num   <= 1'b0;
                        r_blen  <= 4'd1;
                        r_width <= '0;
                    end
                    ACT_CHAR: begin
                        r_num  <= 1'b0;
                        r_blen <= {3'b0, i_item.value[7:0] != 8'd0};
                    end
                    ACT_DEC: r_dig <= '0;
                    ACT_OCT: r_dig <= oct_digits(i_item.value);
                    ACT_HEX: r_dig <= {{(DIG_W-VAL_W){1'b0}}, i_item.value};
                    default: begin
                        r_num   <= 1'b0;
                        r_chr   <= CH_QUEST;
                        r_blen  <= 4'd1;
                        r_width <= '0;
                    end
                endcase
            end
            ST_CONV: begin
                if (bcd_done) begin
                    r_dig <= {{(DIG_W-BCD_W){1'b0}}, bcd_val};
                end
            end
            ST_STRIP: begin
                if (r_dig[DIG_W-1 -: 4] == 4'd0 && r_blen > 4'd1) begin
                    r_dig  <= {r_dig[DIG_W-5:0], 4'b0};
                    r_blen <= r_blen - 4'd1;
                end
            end
            ST_PREP: begin
                r_padn <= (r_width > {2'b0, r_blen}) ? r_width - {2'b0, r_blen} : 6'd0;
            end
            ST_PAD: begin
                r_padn <= r_padn - 6'd1;
            end
            ST_BODY: begin
                r_dig  <= {r_dig[DIG_W-5:0], 4'b0};
                r_blen <= r_blen - 4'd1;
            end
            default: ;
        endcase
    end

endmodule

[sim/tb_printf_field_formatter_top.sv]
// ----------------------------------------------------------------------------
// tb_printf_field_formatter_top
// Self-checking bench for the printf field formatter. A scoreboard class
// predicts the character run of every accepted directive (padding, digits in
// radix 10, 8 and 16, literals, zero characters, unknown codes) and compares
// each strobed character and its last flag in order. A directed set of edge
// cases is followed by random directives under three sender idle profiles.
// ----------------------------------------------------------------------------
module tb_printf_field_formatter_top;
    import pff_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] ACT_UNKNOWN = 3'd5;
    localparam logic [2:0] ACT_SPARE_A = 3'd6;
    localparam logic [2:0] ACT_SPARE_B = 3'd7;
    localparam int         N_PER_PHASE = 53;
    localparam int         DRAIN_CYC   = 80;

    class field_run_board;
        t_out pending_chars[$];
        int   errors;
        int   n_dirs;
        int   n_chars;
        int   act_seen[8];

        function new();
            errors  = 0;
            n_dirs  = 0;
            n_chars = 0;
            foreach (act_seen[i]) act_seen[i] = 0;
        endfunction

        function int pending();
            return pending_chars.size();
        endfunction

        function logic [7:0] glyph(input logic [3:0] dig);
            logic [7:0] g;
            if (dig < 4'd10) begin
                g = CH_ZERO + {4'b0, dig};
            end else begin
                g = CH_UPPER + {4'b0, dig} - 8'd10;
            end
            return g;
        endfunction

        function void note_directive(input t_in d);
            logic [7:0] body[$];
            logic [7:0] run[$];
            logic [31:0] v;
            logic [31:0] radix;
            logic [7:0]  pad;
            t_out        r;
            int          width;
            n_dirs++;
            act_seen[d.action]++;
            width = d.field_width;
            if (width > W_CAP) width = W_CAP;
            pad = d.zero_pad ? CH_ZERO : CH_SPACE;
            case (d.action)
                ACT_LITERAL: begin
                    run.push_back(d.value[7:0]);
                end
                ACT_CHAR, ACT_DEC, ACT_OCT, ACT_HEX: begin
                    if (d.action == ACT_CHAR) begin
                        if (d.value[7:0] != 8'd0) body.push_back(d.value[7:0]);
                    end else begin
                        radix = (d.action == ACT_DEC) ? 32'd10 :
                                (d.action == ACT_OCT) ? 32'd8 : 32'd16;
                        v = d.value;
                        do begin
                            body.push_front(glyph(4'(v % radix)));
                            v = v / radix;
                        end while (v != 0 && body.size() < RUN_LIMIT);
                    end
                    for (int i = body.size(); i < width; i++) run.push_back(pad);
                    foreach (body[i]) begin
                        if (run.size() < RUN_LIMIT) run.push_back(body[i]);
                    end
                end
                default: begin
                    run.push_back(CH_QUEST);
                end
            endcase
            foreach (run[i]) begin
                r.char_out = run[i];
                r.last     = (i == run.size() - 1);
                pending_chars.push_back(r);
            end
        endfunction

        function void check_char(input t_out got);
            t_out want;
            if (pending_chars.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat, expected none, actual char %h last %b",
                         $time, got.char_out, got.last);
                return;
            end
            want = pending_chars.pop_front();
            n_chars++;
            if (got.char_out !== want.char_out) begin
                errors++;
                $display("%0t: char_out mismatch, expected %h, actual %h",
                         $time, want.char_out, got.char_out);
            end
            if (got.last !== want.last) begin
                errors++;
                $display("%0t: last mismatch, expected %b, actual %b",
                         $time, want.last, got.last);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    t_in  i_item;
    logic busy;
    logic o_strobe;
    t_out o_result;

    field_run_board board;

    printf_field_formatter_top u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            board.check_char(o_result);
        end
    end

    function automatic t_in mk_dir(input logic [2:0] act, input logic [31:0] val,
                                   input logic [5:0] wid, input logic zp);
        t_in d;
        d.action      = act;
        d.value       = val;
        d.field_width = wid;
        d.zero_pad    = zp;
        return d;
    endfunction

    function automatic t_in rand_dir();
        logic [2:0]  act;
        logic [31:0] val;
        logic [5:0]  wid;
        if ($urandom_range(0, 19) < 17) begin
            act = 3'($urandom_range(0, 4));
        end else begin
            act = 3'($urandom_range(5, 7));
        end
        case ($urandom_range(0, 3))
            0: val = $urandom_range(0, 9);
            1: val = $urandom;
            2: val = 32'hFFFF_FFFF >> $urandom_range(0, 31);
            default: val = 32'd1 << $urandom_range(0, 31);
        endcase
        if ($urandom_range(0, 9) < 8) begin
            wid = 6'($urandom_range(0, 12));
        end else begin
            wid = 6'($urandom_range(13, 63));
        end
        return mk_dir(act, val, wid, 1'($urandom_range(0, 1)));
    endfunction

    // caller stands at a rising edge; returns at the edge that takes the directive
    task automatic send_dir(input t_in d, input int idle_pct);
        int gap;
        gap = 0;
        while (gap < 6 && $urandom_range(0, 99) < idle_pct) gap++;
        if (gap > 0) begin
            start  <= 1'b0;
            i_item <= t_in'({$urandom, $urandom});
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= d;
        do @(posedge i_clk); while (busy);
        board.note_directive(d);
    endtask

    task automatic run_directed();
        t_in dirs[$];
        dirs.push_back(mk_dir(ACT_LITERAL, 32'h0000_0000, 6'd0,  1'b0));
        dirs.push_back(mk_dir(ACT_LITERAL, 32'hFFFF_FF25, 6'd63, 1'b1));
        dirs.push_back(mk_dir(ACT_CHAR,    32'h0000_0041, 6'd0,  1'b0));
        dirs.push_back(mk_dir(ACT_CHAR,    32'hABCD_EF7A, 6'd32, 1'b1));
        dirs.push_back(mk_dir(ACT_CHAR,    32'h0000_0000, 6'd0,  1'b0));
        dirs.push_back(mk_dir(ACT_CHAR,    32'hFFFF_FF00, 6'd5,  1'b1));
        dirs.push_back(mk_dir(ACT_CHAR,    32'h0000_00FF, 6'd63, 1'b0));
        dirs.push_back(mk_dir(ACT_DEC,     32'h0000_0000, 6'd0,  1'b0));
        dirs.push_back(mk_dir(ACT_DEC,     32'hFFFF_FFFF, 6'd0,  1'b0));
        dirs.push_back(mk_dir(ACT_DEC,     32'd5,         6'd10, 1'b1));
        dirs.push_back(mk_dir(ACT_DEC,     32'd12345,     6'd63, 1'b1));
        dirs.push_back(mk_dir(ACT_DEC,     32'd1000000000, 6'd3, 1'b0));
        dirs.push_back(mk_dir(ACT_OCT,     32'hFFFF_FFFF, 6'd0,  1'b0));
        dirs.push_back(mk_dir(ACT_OCT,     32'h0000_0000, 6'd63, 1'b0));
        dirs.push_back(mk_dir(ACT_OCT,     32'o777,       6'd6,  1'b1));
        dirs.push_back(mk_dir(ACT_HEX,     32'hDEAD_BEEF, 6'd3,  1'b0));
        dirs.push_back(mk_dir(ACT_HEX,     32'h0000_000A, 6'd32, 1'b0));
        dirs.push_back(mk_dir(ACT_HEX,     32'h0123_4567, 6'd33, 1'b1));
        dirs.push_back(mk_dir(ACT_HEX,     32'h89AB_CDEF, 6'd8,  1'b1));
        dirs.push_back(mk_dir(ACT_UNKNOWN, 32'hFFFF_FFFF, 6'd20, 1'b1));
        dirs.push_back(mk_dir(ACT_SPARE_A, 32'h0000_0031, 6'd7,  1'b0));
        dirs.push_back(mk_dir(ACT_SPARE_B, 32'h5555_AAAA, 6'd63, 1'b1));
        foreach (dirs[i]) send_dir(dirs[i], 20);
    endtask

    initial begin
        int sender_idle[3];
        sender_idle[0] = 20;
        sender_idle[1] = 55;
        sender_idle[2] = 0;
        board   = new();
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_item  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        foreach (sender_idle[p]) begin
            for (int i = 0; i < N_PER_PHASE; i++) send_dir(rand_dir(), sender_idle[p]);
        end
        start <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (board.pending() != 0) board.errors++;
        $display("Ran %0d directives (literal %0d, char %0d, dec %0d, oct %0d, hex %0d, other %0d)",
                 board.n_dirs, board.act_seen[0], board.act_seen[1], board.act_seen[2],
                 board.act_seen[3], board.act_seen[4],
                 board.act_seen[5] + board.act_seen[6] + board.act_seen[7]);
        $display("Checked %0d characters over three sender idle profiles, %0d errors",
                 board.n_chars, board.errors);
        if (board.errors == 0) begin
            $display("tb_printf_field_formatter_top: PASS");
        end else begin
            $display("tb_printf_field_formatter_top: FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d characters still outstanding", board.pending());
        $display("tb_printf_field_formatter_top: FAIL");
        $finish;
    end

endmodule
